FILE: hw/rtl/value_rank_assignment_defines.svh
// assertion macros shared by the value rank assignment rtl
// no dependencies; the including module must provide clk and rst
`ifndef VALUE_RANK_ASSIGNMENT_DEFINES_SVH
`define VALUE_RANK_ASSIGNMENT_DEFINES_SVH

// condition holds at every clock edge outside reset
`define VRA_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("value rank assignment check failed");

// consequence holds in the cycle after the trigger
`define VRA_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("value rank assignment check failed");

`endif

FILE: hw/rtl/vra_pkg.sv
// shared types and constants for the value rank assignment block
// no dependencies
package vra_pkg;

  localparam int VAL_W  = 32;
  localparam int RANK_W = 6;

  // value travelling down the cell chain
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic [RANK_W-1:0]       below;
  } tok_t;

  // per-cell contents moved toward the head during unload
  typedef struct packed {
    logic              full;
    logic [RANK_W-1:0] rank;
  } slot_t;

endpackage

FILE: hw/rtl/value_rank_assignment.sv
// value rank assignment: one value per cycle enters; after the last, ranks are emitted
// in load order, one item per cycle while the receiver is ready, from the head of a chain of compare cells
// drain: after the last value, the block waits until every value has settled in its cell
// throughput while loading: one value per cycle; none accepted during drain and unload
// reset (rst, synchronous) empties every cell and clears count and overflow
// depends on vra_pkg, vra_cell and value_rank_assignment_defines.svh
`include "value_rank_assignment_defines.svh"

module value_rank_assignment
  import vra_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value_in
  input  logic        s_axis_tlast,   // last_value
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] rank, [11:6] position, [15:12] zero
  output logic        m_axis_tlast,   // last_rank
  output logic [0:0]  m_axis_tuser    // [0] overflow
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [1:0] {LOAD, DRAIN, UNLOAD} state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;     // values held in this run
  logic [CNT_W-1:0]   out_idx;   // next position to emit
  logic               ovf;       // a value was dropped in this run
  logic [RANK_W-1:0]  out_rank;
  logic [RANK_W-1:0]  out_pos;

  tok_t  link [MAX_ITEMS+1];     // link[0] is the registered input token
  slot_t slot [MAX_ITEMS+1];     // slot[MAX_ITEMS] feeds empty cells into the tail
  logic [MAX_ITEMS:0] busy;
  logic  in_flight;
  logic  s_acc;
  logic  full_list;
  logic  advance;
  logic  shift;
  logic                    head_valid;
  logic signed [VAL_W-1:0] head_value;

  assign s_axis_tready = (state == LOAD);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign full_list     = (count == CNT_W'(MAX_ITEMS));

  // output register may take a new item when empty or being drained
  assign advance = !m_axis_tvalid || m_axis_tready;
  assign shift   = (state == UNLOAD) && advance && (out_idx != count);

  assign m_axis_tdata = {4'b0, out_pos, out_rank};

  // ---------------------------------------------------------------
  // input token: a value that fits enters the head of the chain
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else begin
      head_valid <= s_acc && !full_list;
    end
  end

  always_ff @(posedge clk) begin
    head_value <= $signed(s_axis_tdata);
  end

  assign link[0] = '{valid: head_valid, value: head_value, below: '0};

  // ---------------------------------------------------------------
  // chain of compare cells
  // ---------------------------------------------------------------
  assign slot[MAX_ITEMS] = '{full: 1'b0, rank: '0};

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    vra_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (link[i]),
      .tok_out  (link[i+1]),
      .shift    (shift),
      .slot_in  (slot[i+1]),
      .slot_out (slot[i])
    );
  end

  for (genvar i = 0; i <= MAX_ITEMS; i++) begin : g_busy
    assign busy[i] = link[i].valid;
  end

  // any value still walking toward its cell
  assign in_flight = |busy;

  // ---------------------------------------------------------------
  // sequencer and output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= LOAD;
      count         <= '0;
      out_idx       <= '0;
      ovf           <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tlast  <= 1'b0;
      m_axis_tuser  <= '0;
      out_rank      <= '0;
      out_pos       <= '0;
    end else begin
      // a new item replaces the one taken, otherwise a taken item leaves
      if (shift) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        LOAD: begin
          if (s_acc) begin
            if (full_list) begin
              ovf <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
            if (s_axis_tlast) begin
              state <= DRAIN;
            end
          end
        end
        DRAIN: begin
          if (!in_flight) begin
            state   <= UNLOAD;
            out_idx <= '0;
          end
        end
        UNLOAD: begin
          if (out_idx == count) begin
            // run finished: clear for the next list
            state   <= LOAD;
            count   <= '0;
            ovf     <= 1'b0;
            out_idx <= '0;
          end else if (shift) begin
            out_rank      <= slot[0].rank;
            out_pos       <= RANK_W'(out_idx);
            m_axis_tlast  <= (out_idx == count - CNT_W'(1));
            m_axis_tuser  <= ovf;
            out_idx       <= out_idx + CNT_W'(1);
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  `VRA_ASSERT_NOW(a_shift_settled, !shift || !in_flight)
  `VRA_ASSERT_NOW(a_head_full, !shift || slot[0].full)
  `VRA_ASSERT_NOW(a_count_bound, count <= CNT_W'(MAX_ITEMS))
  `VRA_ASSERT_NEXT(a_last_drains, s_acc && s_axis_tlast, state == DRAIN)

endmodule

FILE: hw/rtl/vra_cell.sv
// one compare cell of the rank chain: holds a value and its running rank
// depends on vra_pkg
module vra_cell
  import vra_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  tok_t  tok_in,
  output tok_t  tok_out,
  input  logic  shift,
  input  slot_t slot_in,
  output slot_t slot_out
);

  logic                    full;
  logic [RANK_W-1:0]       rank;
  logic signed [VAL_W-1:0] value;
  logic                    gt;
  logic                    pass_valid;
  logic signed [VAL_W-1:0] pass_value;
  logic [RANK_W-1:0]       pass_below;

  assign gt       = value > tok_in.value;
  assign slot_out = '{full: full, rank: rank};
  assign tok_out  = '{valid: pass_valid, value: pass_value, below: pass_below};

  always_ff @(posedge clk) begin
    if (rst) begin
      full       <= 1'b0;
      pass_valid <= 1'b0;
    end else begin
      pass_valid <= tok_in.valid && full && !shift;
      if (shift) begin
        full <= slot_in.full;
      end else if (tok_in.valid && !full) begin
        full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pass_value <= tok_in.value;
    pass_below <= tok_in.below + RANK_W'(!gt);
    if (shift) begin
      rank <= slot_in.rank;
    end else if (tok_in.valid) begin
      if (full) begin
        if (gt) begin
          rank <= rank + RANK_W'(1);
        end
      end else begin
        value <= tok_in.value;
        rank  <= tok_in.below;
      end
    end
  end

endmodule

FILE: tb/sv/tb_value_rank_assignment.sv
// self-checking testbench for value_rank_assignment: loads lists of signed values and
// checks every emitted rank, position, last and overflow flag against a local predictor
// depends on vra_pkg and the value_rank_assignment rtl
module tb_value_rank_assignment
  import vra_pkg::*;
();

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 152;
  localparam int DRAIN_CYCLES = CAPACITY + 16;

  // one input item: a list value and its end-of-list mark
  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } list_value_t;

  // one result item as the block should emit it
  typedef struct {
    logic [RANK_W-1:0] rank;
    logic [RANK_W-1:0] position;
    logic              last_rank;
    logic              overflow;
  } rank_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // [31:0] value_in
  logic        s_axis_tlast = 1'b0;  // last_value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [5:0] rank, [11:6] position, [15:12] zero
  logic        m_axis_tlast;         // last_rank
  logic [0:0]  m_axis_tuser;         // [0] overflow

  value_rank_assignment #(
    .MAX_ITEMS(CAPACITY)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // values waiting to be sent, and ranks waiting to come out
  list_value_t  value_queue[$];
  rank_result_t pending_ranks[$];

  // predictor copy of the block's list
  logic signed [VAL_W-1:0] held_value[CAPACITY];
  logic [RANK_W-1:0]       held_rank[CAPACITY];
  int                      held_count = 0;
  logic                    dropped = 1'b0;

  // run statistics
  int fail_count    = 0;
  int values_sent   = 0;
  int runs_done     = 0;
  int overflow_runs = 0;
  int ranks_checked = 0;

  // input accepted at the last rising edge
  logic in_taken = 1'b0;

  // sender burst and gap counters
  int burst_left = 0;
  int gap_left   = 0;

  // receiver stall pattern
  int stall_mode = 0;
  int stall_left = 0;
  int ready_phase = 0;

  task automatic push_value(input logic signed [VAL_W-1:0] v, input logic mark);
    list_value_t item;
    item.value = v;
    item.last  = mark;
    value_queue.push_back(item);
  endtask

  // mix of full-range values, tight clusters that force ties, and the extremes
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom;
      2:    v = $signed($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = '0;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  // rank a new value against the held ones; on the mark, emit the whole list
  task automatic rank_and_load(input logic signed [VAL_W-1:0] v, input logic mark);
    int i;
    int lower;
    rank_result_t r;
    lower = 0;
    if (held_count >= CAPACITY) begin
      // list full: value is dropped, even if it carries the mark
      dropped = 1'b1;
    end else begin
      for (i = 0; i < held_count; i++) begin
        // strictly greater moves up, so ties keep arrival order
        if (held_value[i] > v) held_rank[i] = held_rank[i] + 1'b1;
        else lower++;
      end
      held_value[held_count] = v;
      held_rank[held_count]  = lower[RANK_W-1:0];
      held_count++;
    end
    if (mark) begin
      for (i = 0; i < held_count; i++) begin
        r.rank      = held_rank[i];
        r.position  = i[RANK_W-1:0];
        r.last_rank = (i == held_count - 1);
        r.overflow  = dropped;
        pending_ranks.push_back(r);
      end
      if (dropped) overflow_runs++;
      runs_done++;
      held_count = 0;
      dropped    = 1'b0;
    end
  endtask

  task automatic check_rank(input rank_result_t want);
    if (m_axis_tdata[5:0] !== want.rank) begin
      $error("rank mismatch: expected %0d, got %0d", want.rank, m_axis_tdata[5:0]);
      fail_count++;
    end
    if (m_axis_tdata[11:6] !== want.position) begin
      $error("position mismatch: expected %0d, got %0d", want.position, m_axis_tdata[11:6]);
      fail_count++;
    end
    if (m_axis_tlast !== want.last_rank) begin
      $error("last_rank mismatch: expected %0b, got %0b", want.last_rank, m_axis_tlast);
      fail_count++;
    end
    if (m_axis_tuser[0] !== want.overflow) begin
      $error("overflow mismatch: expected %0b, got %0b", want.overflow, m_axis_tuser[0]);
      fail_count++;
    end
  endtask

  // monitor: sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      // results first: a rank of the previous list may still be leaving
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_ranks.size() == 0) begin
          $error("unexpected rank item: rank %0d position %0d",
                 m_axis_tdata[5:0], m_axis_tdata[11:6]);
          fail_count++;
        end else begin
          check_rank(pending_ranks.pop_front());
          ranks_checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rank_and_load($signed(s_axis_tdata), s_axis_tlast);
        values_sent++;
      end
    end
  end

  // driver: bursts of items with random gaps, changes at the falling edge
  always @(negedge clk) begin
    list_value_t item;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_taken) begin
      // item still waiting for tready, hold it
    end else if (gap_left > 0 || value_queue.size() == 0) begin
      s_axis_tvalid <= 1'b0;
      if (gap_left > 0) gap_left--;
    end else begin
      item = value_queue.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= item.value;
      s_axis_tlast  <= item.last;
      if (burst_left <= 1) begin
        // now and then a long burst with no idling at all
        if ($urandom_range(0, 4) == 0) begin
          burst_left = $urandom_range(30, 80);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = $urandom_range(0, 5);
        end
      end else begin
        burst_left--;
      end
    end
  end

  // receiver: tready follows a stall pattern that is chosen anew at random
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 60);
    end
    stall_left--;
    ready_phase++;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (ready_phase % 4 == 0);
      default: m_axis_tready <= (ready_phase % 7 < 4);
    endcase
  end

  // stimulus and end of run
  initial begin
    int len;
    int run_idx;
    int rand_sent;
    int k;

    // single value, the most negative
    push_value(32'sh8000_0000, 1'b1);
    // two-value list with both extremes, largest first
    push_value(32'sh7fff_ffff, 1'b0);
    push_value(32'sh8000_0000, 1'b1);
    // values around zero and one step inside each extreme
    push_value(0, 1'b0);
    push_value(-1, 1'b0);
    push_value(1, 1'b0);
    push_value(32'sh7fff_fffe, 1'b0);
    push_value(32'sh8000_0001, 1'b1);
    // equal values rank by arrival order
    push_value(5, 1'b0);
    push_value(5, 1'b0);
    push_value(5, 1'b1);
    // ties mixed with distinct values
    push_value(-7, 1'b0);
    push_value(3, 1'b0);
    push_value(-7, 1'b0);
    push_value(3, 1'b0);
    push_value(0, 1'b1);
    // alternating bit patterns
    push_value(32'sh5555_5555, 1'b0);
    push_value(32'shaaaa_aaaa, 1'b1);

    // random lists, mostly short; one overfills the list so unmarked and
    // marked values are dropped and every rank up to the top appears
    run_idx   = 0;
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      if (run_idx == 2) len = CAPACITY + $urandom_range(2, 4);
      else if ($urandom_range(0, 7) == 0) len = $urandom_range(11, 30);
      else len = $urandom_range(1, 10);
      for (k = 0; k < len; k++) push_value(pick_value(), k == len - 1);
      rand_sent += len;
      run_idx++;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all values accepted, then all ranks out, then let the block settle
    while (value_queue.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_ranks.size() != 0) begin
      $error("%0d rank items never arrived", pending_ranks.size());
      fail_count++;
    end

    $display("covered %0d values in %0d lists (%0d with dropped values), %0d ranks checked",
             values_sent, runs_done, overflow_runs, ranks_checked);
    if (fail_count == 0) begin
      $display("value_rank_assignment test passed");
    end else begin
      $display("value_rank_assignment test failed");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #400000;
    $display("value_rank_assignment test failed");
    $finish;
  end

endmodule
